### src/slla_pkg.sv
// Shared types, codes and saturating arithmetic for the least-loaded assign block.
// No dependencies.
package slla_pkg;

	localparam int ACT_W    = 2;
	localparam int WEIGHT_W = 16;
	localparam int BLK_W    = 6;
	localparam int LOAD_W   = 32;
	localparam int CFG_W    = 7;
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 2;

	typedef logic [ACT_W-1:0]    action_t;
	typedef logic [WEIGHT_W-1:0] weight_t;
	typedef logic [BLK_W-1:0]    blk_t;
	typedef logic [LOAD_W-1:0]   load_t;
	typedef logic [CFG_W-1:0]    cfg_t;

	// request action codes
	localparam action_t ACT_CLEAR = 2'd0;
	localparam action_t ACT_ACCUM = 2'd1;
	localparam action_t ACT_PLACE = 2'd2;

	// register word indexes
	localparam int REG_ACTIVE_BLOCKS = 0;

	localparam cfg_t ACTIVE_RESET = 7'd2;

	function automatic load_t sat_add(input load_t a, input weight_t b);
		logic [LOAD_W:0] s;
		s = {1'b0, a} + {{(LOAD_W+1-WEIGHT_W){1'b0}}, b};
		return s[LOAD_W] ? {LOAD_W{1'b1}} : s[LOAD_W-1:0];
	endfunction

	function automatic load_t floor_sub(input load_t a, input weight_t b);
		load_t bx;
		bx = {{(LOAD_W-WEIGHT_W){1'b0}}, b};
		return (a < bx) ? '0 : a - bx;
	endfunction

endpackage

### src/slla_cfg_regs.sv
// APB register file: holds the active block count.
// Depends on slla_pkg.
module slla_cfg_regs import slla_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              active_blocks
);

	cfg_t active_q;
	logic wr_hit;

	// one word register at its byte address
	assign wr_hit = psel && penable && pwrite
		&& (paddr == APB_AW'(REG_ACTIVE_BLOCKS * 4));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (wr_hit) begin
			active_q <= pwdata[CFG_W-1:0];
		end
	end

	assign prdata        = {{(APB_DW-CFG_W){1'b0}}, active_q};
	assign pready        = 1'b1;
	assign active_blocks = active_q;

endmodule

### src/slla_tot_mem.sv
// Block totals memory: one write port, one read port, registered read data.
// Depends on slla_pkg.
module slla_tot_mem import slla_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  load_t         wdata,
	input  logic [AW-1:0] raddr,
	output load_t         rdata
);

	load_t mem [DEPTH];
	load_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### src/slla_min_scan.sv
// Running minimum over totals streamed from memory; lowest index wins ties.
// Depends on slla_pkg.
module slla_min_scan import slla_pkg::*; #(
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          issue,     // read issued this cycle
	input  logic [AW-1:0] issue_idx,
	input  load_t         rd_load,   // read data, arriving the cycle after issue
	output logic [AW-1:0] best_idx,
	output load_t         best_load
);

	logic          vld_s1;
	logic [AW-1:0] idx_s1;
	logic [AW-1:0] best_idx_q;
	load_t         best_load_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= issue_idx;
		// entry 0 seeds the search
		if (vld_s1 && (idx_s1 == '0 || rd_load < best_load_q)) begin
			best_idx_q  <= idx_s1;
			best_load_q <= rd_load;
		end
	end

	assign best_idx  = best_idx_q;
	assign best_load = best_load_q;

endmodule

### src/singleton_least_loaded_assign.sv
// Least-loaded placement of isolated nodes: top level with request sequencer.
// Depends on slla_pkg, slla_cfg_regs, slla_tot_mem, slla_min_scan.
//
// One request at a time: a request is taken when start is high and busy is low.
// A clear request sweeps the totals memory to zero, one entry per cycle; the
// same sweep runs straight after reset, so no request is taken until it ends
// (register writes are taken throughout). An accumulate request is a
// read-modify-write of one total (none if the block lies outside the
// memory). A place request streams the active totals out of the memory, one
// per cycle, through a running minimum (lowest index on ties), then does two
// read-modify-writes: take the weight off the old block (floored at zero, and
// skipped if that block lies outside the memory), then add it to the chosen
// block (saturated). The number of blocks searched is active_blocks, 0 read
// as 1, capped at MAX_BLOCKS. The result appears on chosen_block/chosen_load
// for exactly one cycle with done high, in the same cycle that busy falls;
// there is no back-pressure, so the receiver must take it then. Clear,
// accumulate and action code 3 give no result. active_blocks must only be
// written while idle.
module singleton_least_loaded_assign import slla_pkg::*; #(
	parameter int MAX_BLOCKS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              start,
	output logic              busy,
	input  action_t           action,
	input  weight_t           node_weight,
	input  blk_t              current_block,
	// result channel
	output logic              done,
	output blk_t              chosen_block,
	output load_t             chosen_load,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	// compare width wide enough for both the register and the block count
	localparam int CW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
	localparam logic [CW-1:0] MAXB = CW'(MAX_BLOCKS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_BLOCKS - 1);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_CLR    = 4'd1;
	localparam logic [3:0] ST_SCAN   = 4'd2;
	localparam logic [3:0] ST_SUB_RD = 4'd3;
	localparam logic [3:0] ST_SUB_WR = 4'd4;
	localparam logic [3:0] ST_ADD_RD = 4'd5;
	localparam logic [3:0] ST_ADD_WR = 4'd6;
	localparam logic [3:0] ST_ACC_RD = 4'd7;
	localparam logic [3:0] ST_ACC_WR = 4'd8;

	logic [3:0]    state_q;
	logic [AW-1:0] ptr_q;       // sweep / scan address
	logic [AW-1:0] last_q;      // last block searched
	logic [AW-1:0] blk_q;
	logic          blk_ok_q;    // request block lies inside the memory
	weight_t       weight_q;
	logic          done_q;
	blk_t          chosen_block_q;
	load_t         chosen_load_q;

	cfg_t          active_blocks;
	logic          accept;
	logic          blk_ok;
	logic [CW-1:0] act_ext;
	logic [AW-1:0] last_d;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	load_t         mem_wdata;
	logic [AW-1:0] mem_raddr;
	load_t         mem_rdata;

	logic          scan_issue;
	logic [AW-1:0] best_idx;
	load_t         best_load;

	slla_cfg_regs u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.active_blocks (active_blocks)
	);

	slla_tot_mem #(
		.DEPTH (MAX_BLOCKS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	slla_min_scan #(
		.AW (AW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (scan_issue),
		.issue_idx (ptr_q),
		.rd_load   (mem_rdata),
		.best_idx  (best_idx),
		.best_load (best_load)
	);

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign blk_ok = ({{(CW-BLK_W){1'b0}}, current_block} < MAXB);

	// search bound: zero reads as one block, capped at the memory depth
	assign act_ext = {{(CW-CFG_W){1'b0}}, active_blocks};
	always_comb begin
		if (act_ext == '0) begin
			last_d = '0;
		end else if (act_ext > MAXB) begin
			last_d = LAST_ADDR;
		end else begin
			last_d = AW'(act_ext - CW'(1));
		end
	end

	assign scan_issue = (state_q == ST_SCAN);

	// memory port steering
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = blk_q;
		mem_wdata = '0;
		mem_raddr = blk_q;
		case (state_q)
			ST_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q;
			end
			ST_SCAN: begin
				mem_raddr = ptr_q;
			end
			ST_SUB_WR: begin
				mem_we    = blk_ok_q;
				mem_wdata = floor_sub(mem_rdata, weight_q);
			end
			ST_ADD_RD: begin
				mem_raddr = best_idx;
			end
			ST_ADD_WR: begin
				mem_we    = 1'b1;
				mem_waddr = best_idx;
				mem_wdata = sat_add(mem_rdata, weight_q);
			end
			ST_ACC_WR: begin
				mem_we    = 1'b1;
				mem_wdata = sat_add(mem_rdata, weight_q);
			end
			default: begin
			end
		endcase
	end

	// sequencer; after reset the totals are swept to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			ptr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					ptr_q <= '0;
					if (accept) begin
						case (action)
							ACT_CLEAR: state_q <= ST_CLR;
							ACT_ACCUM: state_q <= blk_ok ? ST_ACC_RD : ST_IDLE;
							ACT_PLACE: state_q <= ST_SCAN;
							default:   state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CLR: begin
					ptr_q <= ptr_q + AW'(1);
					if (ptr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					ptr_q <= ptr_q + AW'(1);
					if (ptr_q == last_q) begin
						state_q <= ST_SUB_RD;
					end
				end
				// last compare of the scan lands alongside the old-block read
				ST_SUB_RD: state_q <= ST_SUB_WR;
				ST_SUB_WR: state_q <= ST_ADD_RD;
				ST_ADD_RD: state_q <= ST_ADD_WR;
				ST_ADD_WR: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				ST_ACC_RD: state_q <= ST_ACC_WR;
				ST_ACC_WR: state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	// request fields and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			weight_q <= node_weight;
			blk_q    <= AW'(current_block);
			blk_ok_q <= blk_ok;
			last_q   <= last_d;
		end
		if (state_q == ST_ADD_WR) begin
			chosen_block_q <= BLK_W'(best_idx);
			chosen_load_q  <= best_load;
		end
	end

	assign done         = done_q;
	assign chosen_block = chosen_block_q;
	assign chosen_load  = chosen_load_q;

endmodule
